// ===== rtl/slcd_pkg.sv =====
// slcd_pkg: shared types and constants for the sync/length/checksum deframer.
// Holds the verdict codes, configuration register indexes and field widths.
// No dependencies.
package slcd_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 17;
  localparam int LEN_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;

  // Frame layout: sync, sync, free byte, length low, length high, ...
  localparam logic [POS_W-1:0] POS_SYNC0   = 17'd0;
  localparam logic [POS_W-1:0] POS_SYNC1   = 17'd1;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd3;
  localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd4;
  // Last byte of a frame sits at length + 7 (frame is length + 8 bytes)
  localparam logic [POS_W-1:0] TAIL_OFFSET = 17'd7;

  // Register reset values
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hA5;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h01;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 16'd4088;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MAX_PAYLOAD = 2'd2
  } cfg_idx_t;

  // Per-beat verdict carried on the result channel
  typedef enum logic [2:0] {
    VERD_PENDING = 3'd0,
    VERD_GOOD    = 3'd1,
    VERD_BADSUM  = 3'd2,
    VERD_BADHDR  = 3'd3,
    VERD_TOOLONG = 3'd4
  } verdict_t;

  // Output tdata: byte, position, length, zero fill to 48 bits
  localparam int OUT_DATA_W = 48;

endpackage

// ===== rtl/sync_length_checksum_deframer.sv =====
// sync_length_checksum_deframer: cut-through byte stream deframer with sync,
// length and two's-complement checksum checks.
// Depends on slcd_pkg.
//
// Channel | Dir | Beat contents
// --------+-----+---------------------------------------------------------
// in_     | in  | tdata: data_byte
// out_    | out | tdata: out_byte, byte_position, payload_length; tuser:
//         |     | verdict; tlast: frame_last
// cfg_    | in  | write enable, register index, data (no handshake)
//
// One beat per cycle unless stalled; each byte's result is out next cycle.
// Frame checks are a counter step, an 8-bit add and a few compares between
// the input and the result register.
// in_tready drops only while a result beat is held and out_tready is low.
// rst_n is synchronous, active low; it clears the frame state and loads the
// register reset values.
module sync_length_checksum_deframer
  import slcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] data_byte
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] out_byte, [24:8] byte_position,
                                            // [40:25] payload_length, [47:41] zero
  output logic [2:0]            out_tuser,  // [2:0] verdict
  output logic                  out_tlast,  // frame_last
  // configuration
  input  logic                  cfg_we,
  input  logic [CIDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // Configuration registers
  logic [BYTE_W-1:0] sync_first_r;
  logic [BYTE_W-1:0] sync_second_r;
  logic [LEN_W-1:0]  max_payload_r;

  // Frame state
  logic [POS_W-1:0]  pos_r;
  logic [LEN_W-1:0]  len_r;
  logic [BYTE_W-1:0] sum_r;
  logic              hdr_ok_r;

  // Result register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [LEN_W-1:0]  out_len_r;
  verdict_t          out_verd_r;
  logic              out_last_r;

  // Combinational frame step
  logic              acc;
  logic              hdr_ok_c;
  logic [LEN_W-1:0]  len_c;
  logic [LEN_W-1:0]  plen_c;
  logic [BYTE_W-1:0] sum_c;
  logic [POS_W-1:0]  tail_pos_c;
  verdict_t          verd_c;
  logic              last_c;

  // Handshake: output register frees up as it drains
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  // Header capture and frame judgement for the byte at the input
  always_comb begin
    hdr_ok_c   = hdr_ok_r;
    len_c      = len_r;
    if (pos_r == POS_SYNC0) begin
      hdr_ok_c = (in_tdata == sync_first_r);
    end else if (pos_r == POS_SYNC1) begin
      if (in_tdata != sync_second_r) begin
        hdr_ok_c = 1'b0;
      end
    end else if (pos_r == POS_LEN_LO) begin
      len_c = {{(LEN_W-BYTE_W){1'b0}}, in_tdata};
    end else if (pos_r == POS_LEN_HI) begin
      len_c = {in_tdata, len_r[BYTE_W-1:0]};
    end

    plen_c     = (pos_r >= POS_LEN_HI) ? len_c : '0;
    sum_c      = sum_r + in_tdata;
    tail_pos_c = {1'b0, len_c} + TAIL_OFFSET;

    verd_c = VERD_PENDING;
    last_c = 1'b0;
    if (pos_r == POS_LEN_HI && !hdr_ok_c) begin
      verd_c = VERD_BADHDR;
      last_c = 1'b1;
    end else if (pos_r == POS_LEN_HI && len_c > max_payload_r) begin
      verd_c = VERD_TOOLONG;
      last_c = 1'b1;
    end else if (pos_r >= POS_LEN_HI && pos_r == tail_pos_c) begin
      verd_c = (sum_c == '0) ? VERD_GOOD : VERD_BADSUM;
      last_c = 1'b1;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata[BYTE_W-1:0];
        CFG_SYNC_SECOND: sync_second_r <= cfg_wdata[BYTE_W-1:0];
        CFG_MAX_PAYLOAD: max_payload_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame state: advance per beat, clear on frame end or abort
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      len_r    <= '0;
      sum_r    <= '0;
      hdr_ok_r <= 1'b0;
    end else if (acc) begin
      if (last_c) begin
        pos_r    <= '0;
        len_r    <= '0;
        sum_r    <= '0;
        hdr_ok_r <= 1'b0;
      end else begin
        pos_r    <= pos_r + 1'b1;
        len_r    <= len_c;
        sum_r    <= sum_c;
        hdr_ok_r <= hdr_ok_c;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (acc) begin
      out_byte_r <= in_tdata;
      out_pos_r  <= pos_r;
      out_len_r  <= plen_c;
      out_verd_r <= verd_c;
      out_last_r <= last_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-BYTE_W-POS_W-LEN_W){1'b0}},
                       out_len_r, out_pos_r, out_byte_r};
  assign out_tuser  = out_verd_r;
  assign out_tlast  = out_last_r;

  // Checks
  a_last_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_verd_r != VERD_PENDING)))
    else $error("frame_last and verdict disagree");

  a_end_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last_c) |=> (pos_r == '0 && sum_r == '0))
    else $error("frame state not cleared after frame end");

  a_step_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !last_c) |=> (pos_r == $past(pos_r) + 1'b1))
    else $error("position did not advance by one");

  a_hdr_end_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_verd_r == VERD_BADHDR || out_verd_r == VERD_TOOLONG))
      |-> (out_pos_r == POS_LEN_HI))
    else $error("header verdict away from header end");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_pos_r)))
    else $error("result beat changed while stalled");

endmodule
